// ----- hdl/gdsii_rcb_pkg.sv -----
`timescale 1ns / 1ps
package gdsii_rcb_pkg;

    localparam logic [7:0] RT_HEADER   = 8'h00;
    localparam logic [7:0] RT_BGNLIB   = 8'h01;
    localparam logic [7:0] RT_LIBNAME  = 8'h02;
    localparam logic [7:0] RT_UNITS    = 8'h03;
    localparam logic [7:0] RT_ENDLIB   = 8'h04;
    localparam logic [7:0] RT_BGNSTR   = 8'h05;
    localparam logic [7:0] RT_STRNAME  = 8'h06;
    localparam logic [7:0] RT_ENDSTR   = 8'h07;
    localparam logic [7:0] RT_BOUNDARY = 8'h08;
    localparam logic [7:0] RT_PATH     = 8'h09;
    localparam logic [7:0] RT_SREF     = 8'h0A;
    localparam logic [7:0] RT_AREF     = 8'h0B;
    localparam logic [7:0] RT_LAYER    = 8'h0D;
    localparam logic [7:0] RT_DATATYPE = 8'h0E;
    localparam logic [7:0] RT_WIDTH    = 8'h0F;
    localparam logic [7:0] RT_XY       = 8'h10;
    localparam logic [7:0] RT_ENDEL    = 8'h11;
    localparam logic [7:0] RT_SNAME    = 8'h12;
    localparam logic [7:0] RT_COLROW   = 8'h13;
    localparam logic [7:0] RT_NODE     = 8'h15;
    localparam logic [7:0] RT_STRANS   = 8'h1A;
    localparam logic [7:0] RT_MAG      = 8'h1B;
    localparam logic [7:0] RT_ANGLE    = 8'h1C;
    localparam logic [7:0] RT_PATHTYPE = 8'h21;
    localparam logic [7:0] RT_NODETYPE = 8'h2A;
    localparam logic [7:0] RT_BOX      = 8'h2D;
    localparam logic [7:0] RT_BOXTYPE  = 8'h2E;
    localparam logic [7:0] RT_BGNEXTN  = 8'h30;
    localparam logic [7:0] RT_ENDEXTN  = 8'h31;

    localparam logic [7:0] DT_ANY    = 8'hFF;
    localparam logic [7:0] DT_NODATA = 8'h00;
    localparam logic [7:0] DT_BITS   = 8'h01;
    localparam logic [7:0] DT_S16    = 8'h02;
    localparam logic [7:0] DT_S32    = 8'h03;
    localparam logic [7:0] DT_REAL8  = 8'h05;
    localparam logic [7:0] DT_ASCII  = 8'h06;

    localparam logic [2:0] EL_NONE     = 3'd0;
    localparam logic [2:0] EL_BOUNDARY = 3'd1;
    localparam logic [2:0] EL_PATH     = 3'd2;
    localparam logic [2:0] EL_SREF     = 3'd3;
    localparam logic [2:0] EL_AREF     = 3'd4;
    localparam logic [2:0] EL_NODE     = 3'd5;
    localparam logic [2:0] EL_BOX      = 3'd6;
    localparam logic [2:0] EL_NOREQ    = 3'd7;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DTYPE   = 3'd1;
    localparam logic [2:0] ST_ELEMENT = 3'd2;
    localparam logic [2:0] ST_SREF_XY = 3'd3;
    localparam logic [2:0] ST_LENGTH  = 3'd4;

    localparam logic [15:0] SREF_XY_LEN = 16'd12;
    localparam logic [15:0] HDR_LEN     = 16'd4;

    localparam logic signed [31:0] BOX_MIN_INIT = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] BOX_MAX_INIT = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] xmin;
        logic signed [31:0] xmax;
        logic signed [31:0] ymin;
        logic signed [31:0] ymax;
    } box_t;

    localparam box_t BOX_EMPTY = '{BOX_MIN_INIT, BOX_MAX_INIT, BOX_MIN_INIT, BOX_MAX_INIT};

    function automatic logic [7:0] expected_dtype(input logic [7:0] k);
        logic [7:0] r;
        case (k) inside
            RT_HEADER, RT_BGNLIB, RT_BGNSTR, RT_LAYER, RT_DATATYPE, RT_COLROW,
            RT_PATHTYPE, RT_NODETYPE, RT_BOXTYPE:                    r = DT_S16;
            RT_LIBNAME, RT_STRNAME, RT_SNAME:                         r = DT_ASCII;
            RT_UNITS, RT_MAG, RT_ANGLE:                               r = DT_REAL8;
            RT_ENDLIB, RT_ENDSTR, RT_BOUNDARY, RT_PATH, RT_SREF, RT_AREF,
            RT_ENDEL, RT_NODE, RT_BOX:                                r = DT_NODATA;
            RT_WIDTH, RT_XY, RT_BGNEXTN, RT_ENDEXTN:                  r = DT_S32;
            RT_STRANS:                                                r = DT_BITS;
            default:                                                  r = DT_ANY;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] required_element(input logic [7:0] k);
        logic [2:0] r;
        case (k) inside
            RT_WIDTH, RT_PATHTYPE, RT_BGNEXTN, RT_ENDEXTN: r = EL_PATH;
            RT_COLROW:                                     r = EL_AREF;
            RT_NODETYPE:                                   r = EL_NODE;
            RT_BOXTYPE:                                    r = EL_BOX;
            default:                                       r = EL_NOREQ;
        endcase
        return r;
    endfunction

    function automatic box_t box_fold(input box_t b, input logic signed [31:0] x,
                                      input logic signed [31:0] y);
        box_t r;
        r = b;
        if (x < b.xmin) r.xmin = x;
        if (x > b.xmax) r.xmax = x;
        if (y < b.ymin) r.ymin = y;
        if (y > b.ymax) r.ymax = y;
        return r;
    endfunction

endpackage

// ----- hdl/gdsii_record_checker_bbox_unit.sv -----
`timescale 1ns / 1ps
// latency: a record's result is registered on the transfer of its last byte (the
// fourth header byte on a length error), visible on m_ the next cycle
// throughput: one stream byte per cycle while s_ready is high; the output register
// takes a new result while m_ready is high or the register is empty
// reset (aresetn low, synchronous): parser at record start, boxes empty, not halted
module gdsii_record_checker_bbox_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_stream_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_rec_kind,
    output logic [2:0]         m_status,
    output logic [2:0]         m_element,
    output logic [63:0]        m_value_raw,
    output logic signed [31:0] m_poly_xmin,
    output logic signed [31:0] m_poly_xmax,
    output logic signed [31:0] m_poly_ymin,
    output logic signed [31:0] m_poly_ymax,
    output logic signed [31:0] m_cell_xmin,
    output logic signed [31:0] m_cell_xmax,
    output logic signed [31:0] m_cell_ymin,
    output logic signed [31:0] m_cell_ymax
);

    logic [15:0]                byte_pos_reg, byte_pos_next;
    logic [15:0]                rec_len_reg, rec_len_next;
    logic [7:0]                 kind_reg, kind_next;
    logic [7:0]                 dtype_reg, dtype_next;
    logic [2:0]                 elem_reg, elem_next;
    logic [63:0]                head_reg, head_next;
    logic [63:0]                shift_reg, shift_next;
    gdsii_rcb_pkg::box_t        poly_reg, poly_next;
    gdsii_rcb_pkg::box_t        cell_reg, cell_next;
    logic                       halted_reg, halted_next;

    logic                       out_valid_reg;
    logic [7:0]                 out_kind_reg;
    logic [2:0]                 out_status_reg;
    logic [2:0]                 out_elem_reg;
    logic [63:0]                out_head_reg;
    gdsii_rcb_pkg::box_t        out_poly_reg;
    gdsii_rcb_pkg::box_t        out_cell_reg;

    logic                       emit;
    logic [2:0]                 emit_status;
    logic                       take;
    logic [15:0]                d;
    logic [15:0]                pos_inc;
    logic [7:0]                 exp_dt;
    logic [2:0]                 req_el;
    logic [2:0]                 fin_status;
    logic                       fin_now;

    assign s_ready = !out_valid_reg || m_ready;
    assign take    = s_valid && s_ready;
    assign d       = byte_pos_reg - 16'd4;
    assign pos_inc = byte_pos_reg + 16'd1;

    always_comb begin
        byte_pos_next = byte_pos_reg;
        rec_len_next  = rec_len_reg;
        kind_next     = kind_reg;
        dtype_next    = dtype_reg;
        elem_next     = elem_reg;
        head_next     = head_reg;
        shift_next    = shift_reg;
        poly_next     = poly_reg;
        cell_next     = cell_reg;
        halted_next   = halted_reg;
        emit          = 1'b0;
        emit_status   = gdsii_rcb_pkg::ST_OK;
        fin_now       = 1'b0;
        exp_dt        = gdsii_rcb_pkg::expected_dtype(kind_reg);
        req_el        = gdsii_rcb_pkg::required_element(kind_reg);

        // status of finishing record (kind and dtype as they will be)
        if (byte_pos_reg == 16'd3) begin
            exp_dt = gdsii_rcb_pkg::expected_dtype(kind_reg);
        end
        fin_status = gdsii_rcb_pkg::ST_OK;

        if (take && !halted_reg) begin
            case (byte_pos_reg)
                16'd0: begin
                    rec_len_next  = {s_stream_byte, 8'h00};
                    head_next     = '0;
                    shift_next    = '0;
                    byte_pos_next = 16'd1;
                end
                16'd1: begin
                    rec_len_next  = {rec_len_reg[15:8], s_stream_byte};
                    byte_pos_next = 16'd2;
                end
                16'd2: begin
                    kind_next     = s_stream_byte;
                    byte_pos_next = 16'd3;
                end
                16'd3: begin
                    dtype_next = s_stream_byte;
                    if (rec_len_reg < gdsii_rcb_pkg::HDR_LEN || rec_len_reg[0]) begin
                        emit          = 1'b1;
                        emit_status   = gdsii_rcb_pkg::ST_LENGTH;
                        halted_next   = 1'b1;
                        byte_pos_next = '0;
                    end else if (rec_len_reg == gdsii_rcb_pkg::HDR_LEN) begin
                        fin_now       = 1'b1;
                        byte_pos_next = '0;
                    end else begin
                        byte_pos_next = 16'd4;
                    end
                end
                default: begin
                    if (d < 16'd8) begin
                        head_next[63 - 8*d[2:0] -: 8] = s_stream_byte;
                    end
                    shift_next = {shift_reg[55:0], s_stream_byte};
                    if (kind_reg == gdsii_rcb_pkg::RT_XY && dtype_reg == gdsii_rcb_pkg::DT_S32
                        && elem_reg == gdsii_rcb_pkg::EL_BOUNDARY && d[2:0] == 3'd7) begin
                        poly_next = gdsii_rcb_pkg::box_fold(poly_reg, shift_next[63:32],
                                                            shift_next[31:0]);
                        cell_next = gdsii_rcb_pkg::box_fold(cell_reg, shift_next[63:32],
                                                            shift_next[31:0]);
                    end
                    if ({1'b0, pos_inc} >= {1'b0, rec_len_reg} || pos_inc == 16'd0) begin
                        fin_now       = 1'b1;
                        byte_pos_next = '0;
                    end else begin
                        byte_pos_next = pos_inc;
                    end
                end
            endcase

            if (fin_now) begin
                exp_dt = gdsii_rcb_pkg::expected_dtype(kind_reg);
                req_el = gdsii_rcb_pkg::required_element(kind_reg);
                if (exp_dt != gdsii_rcb_pkg::DT_ANY && dtype_next != exp_dt) begin
                    fin_status = gdsii_rcb_pkg::ST_DTYPE;
                end else if (req_el != gdsii_rcb_pkg::EL_NOREQ && elem_reg != req_el) begin
                    fin_status = gdsii_rcb_pkg::ST_ELEMENT;
                end else if (kind_reg == gdsii_rcb_pkg::RT_XY
                             && elem_reg == gdsii_rcb_pkg::EL_SREF
                             && rec_len_reg != gdsii_rcb_pkg::SREF_XY_LEN) begin
                    fin_status = gdsii_rcb_pkg::ST_SREF_XY;
                end
                if (fin_status == gdsii_rcb_pkg::ST_OK) begin
                    case (kind_reg)
                        gdsii_rcb_pkg::RT_BGNSTR:   cell_next = gdsii_rcb_pkg::BOX_EMPTY;
                        gdsii_rcb_pkg::RT_BOUNDARY: begin
                            elem_next = gdsii_rcb_pkg::EL_BOUNDARY;
                            poly_next = gdsii_rcb_pkg::BOX_EMPTY;
                        end
                        gdsii_rcb_pkg::RT_PATH:     elem_next = gdsii_rcb_pkg::EL_PATH;
                        gdsii_rcb_pkg::RT_SREF:     elem_next = gdsii_rcb_pkg::EL_SREF;
                        gdsii_rcb_pkg::RT_AREF:     elem_next = gdsii_rcb_pkg::EL_AREF;
                        gdsii_rcb_pkg::RT_NODE:     elem_next = gdsii_rcb_pkg::EL_NODE;
                        gdsii_rcb_pkg::RT_BOX:      elem_next = gdsii_rcb_pkg::EL_BOX;
                        gdsii_rcb_pkg::RT_ENDEL:    elem_next = gdsii_rcb_pkg::EL_NONE;
                        default: ;
                    endcase
                end
                if (fin_status != gdsii_rcb_pkg::ST_OK
                    || kind_reg == gdsii_rcb_pkg::RT_ENDLIB) begin
                    halted_next = 1'b1;
                end
                emit        = 1'b1;
                emit_status = fin_status;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg  <= '0;
            rec_len_reg   <= '0;
            kind_reg      <= '0;
            dtype_reg     <= '0;
            elem_reg      <= gdsii_rcb_pkg::EL_NONE;
            head_reg      <= '0;
            shift_reg     <= '0;
            poly_reg      <= gdsii_rcb_pkg::BOX_EMPTY;
            cell_reg      <= gdsii_rcb_pkg::BOX_EMPTY;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            byte_pos_reg <= byte_pos_next;
            rec_len_reg  <= rec_len_next;
            kind_reg     <= kind_next;
            dtype_reg    <= dtype_next;
            elem_reg     <= elem_next;
            head_reg     <= head_next;
            shift_reg    <= shift_next;
            poly_reg     <= poly_next;
            cell_reg     <= cell_next;
            halted_reg   <= halted_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, values as the record is emitted (state after this byte's updates,
    // including the box fold and element change at the record's end)
    always_ff @(posedge aclk) begin
        if (emit) begin
            out_kind_reg   <= kind_next;
            out_status_reg <= emit_status;
            out_elem_reg   <= elem_next;
            out_head_reg   <= head_next;
            out_poly_reg   <= poly_next;
            out_cell_reg   <= cell_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_rec_kind  = out_kind_reg;
    assign m_status    = out_status_reg;
    assign m_element   = out_elem_reg;
    assign m_value_raw = out_head_reg;
    assign m_poly_xmin = out_poly_reg.xmin;
    assign m_poly_xmax = out_poly_reg.xmax;
    assign m_poly_ymin = out_poly_reg.ymin;
    assign m_poly_ymax = out_poly_reg.ymax;
    assign m_cell_xmin = out_cell_reg.xmin;
    assign m_cell_xmax = out_cell_reg.xmax;
    assign m_cell_ymin = out_cell_reg.ymin;
    assign m_cell_ymax = out_cell_reg.ymax;

endmodule

// ----- test/gdsii_record_checker_bbox_unit_tb.sv -----
`timescale 1ns / 1ps
module gdsii_record_checker_bbox_unit_tb;

    localparam int LIMIT = 400000;

    typedef struct {
        logic [7:0]          kind;
        logic [2:0]          status;
        logic [2:0]          element;
        logic [63:0]         raw;
        gdsii_rcb_pkg::box_t pbox;
        gdsii_rcb_pkg::box_t cbox;
    } rec_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [7:0] s_stream_byte = 8'h00;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [7:0] m_rec_kind;
    logic [2:0] m_status;
    logic [2:0] m_element;
    logic [63:0] m_value_raw;
    logic signed [31:0] m_poly_xmin, m_poly_xmax, m_poly_ymin, m_poly_ymax;
    logic signed [31:0] m_cell_xmin, m_cell_xmax, m_cell_ymin, m_cell_ymax;

    gdsii_record_checker_bbox_unit DUT (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    logic [7:0]  stream_q[$];
    logic [7:0]  body_q[$];
    rec_result_t result_q[$];
    int errors = 0;
    int cycle_no = 0;
    int sent = 0;
    int pause_point = 0;

    // parser copy
    int                  p_pos = 0;
    int                  p_len = 0;
    logic [7:0]          p_kind = 0;
    logic [7:0]          p_dtype = 0;
    logic [2:0]          p_elem = gdsii_rcb_pkg::EL_NONE;
    logic [63:0]         p_head = 0;
    logic [63:0]         p_shift = 0;
    gdsii_rcb_pkg::box_t p_pbox = gdsii_rcb_pkg::BOX_EMPTY;
    gdsii_rcb_pkg::box_t p_cbox = gdsii_rcb_pkg::BOX_EMPTY;
    logic                p_halted = 1'b0;

    function automatic logic [7:0] dtype_of(input logic [7:0] k);
        case (k)
            gdsii_rcb_pkg::RT_HEADER, gdsii_rcb_pkg::RT_BGNLIB, gdsii_rcb_pkg::RT_BGNSTR,
            gdsii_rcb_pkg::RT_LAYER, gdsii_rcb_pkg::RT_DATATYPE, gdsii_rcb_pkg::RT_COLROW,
            gdsii_rcb_pkg::RT_PATHTYPE, gdsii_rcb_pkg::RT_NODETYPE,
            gdsii_rcb_pkg::RT_BOXTYPE: return gdsii_rcb_pkg::DT_S16;
            gdsii_rcb_pkg::RT_LIBNAME, gdsii_rcb_pkg::RT_STRNAME,
            gdsii_rcb_pkg::RT_SNAME: return gdsii_rcb_pkg::DT_ASCII;
            gdsii_rcb_pkg::RT_UNITS, gdsii_rcb_pkg::RT_MAG,
            gdsii_rcb_pkg::RT_ANGLE: return gdsii_rcb_pkg::DT_REAL8;
            gdsii_rcb_pkg::RT_ENDLIB, gdsii_rcb_pkg::RT_ENDSTR, gdsii_rcb_pkg::RT_BOUNDARY,
            gdsii_rcb_pkg::RT_PATH, gdsii_rcb_pkg::RT_SREF, gdsii_rcb_pkg::RT_AREF,
            gdsii_rcb_pkg::RT_ENDEL, gdsii_rcb_pkg::RT_NODE,
            gdsii_rcb_pkg::RT_BOX: return gdsii_rcb_pkg::DT_NODATA;
            gdsii_rcb_pkg::RT_WIDTH, gdsii_rcb_pkg::RT_XY, gdsii_rcb_pkg::RT_BGNEXTN,
            gdsii_rcb_pkg::RT_ENDEXTN: return gdsii_rcb_pkg::DT_S32;
            gdsii_rcb_pkg::RT_STRANS: return gdsii_rcb_pkg::DT_BITS;
            default: return gdsii_rcb_pkg::DT_ANY;
        endcase
    endfunction

    function automatic logic [2:0] owner_of(input logic [7:0] k);
        case (k)
            gdsii_rcb_pkg::RT_WIDTH, gdsii_rcb_pkg::RT_PATHTYPE, gdsii_rcb_pkg::RT_BGNEXTN,
            gdsii_rcb_pkg::RT_ENDEXTN: return gdsii_rcb_pkg::EL_PATH;
            gdsii_rcb_pkg::RT_COLROW: return gdsii_rcb_pkg::EL_AREF;
            gdsii_rcb_pkg::RT_NODETYPE: return gdsii_rcb_pkg::EL_NODE;
            gdsii_rcb_pkg::RT_BOXTYPE: return gdsii_rcb_pkg::EL_BOX;
            default: return gdsii_rcb_pkg::EL_NOREQ;
        endcase
    endfunction

    function automatic gdsii_rcb_pkg::box_t grow(input gdsii_rcb_pkg::box_t b,
                                                 input logic signed [31:0] x,
                                                 input logic signed [31:0] y);
        gdsii_rcb_pkg::box_t r;
        r = b;
        if (x < r.xmin) r.xmin = x;
        if (x > r.xmax) r.xmax = x;
        if (y < r.ymin) r.ymin = y;
        if (y > r.ymax) r.ymax = y;
        return r;
    endfunction

    function automatic void post_result(input logic [2:0] st);
        rec_result_t r;
        r.kind = p_kind;
        r.status = st;
        r.element = p_elem;
        r.raw = p_head;
        r.pbox = p_pbox;
        r.cbox = p_cbox;
        result_q.push_back(r);
    endfunction

    function automatic void close_record();
        logic [7:0] dt;
        logic [2:0] el;
        logic [2:0] st;
        dt = dtype_of(p_kind);
        el = owner_of(p_kind);
        st = gdsii_rcb_pkg::ST_OK;
        if (dt != gdsii_rcb_pkg::DT_ANY && p_dtype != dt) st = gdsii_rcb_pkg::ST_DTYPE;
        else if (el != gdsii_rcb_pkg::EL_NOREQ && p_elem != el) st = gdsii_rcb_pkg::ST_ELEMENT;
        else if (p_kind == gdsii_rcb_pkg::RT_XY && p_elem == gdsii_rcb_pkg::EL_SREF
                 && p_len != int'(gdsii_rcb_pkg::SREF_XY_LEN)) st = gdsii_rcb_pkg::ST_SREF_XY;
        if (st == gdsii_rcb_pkg::ST_OK) begin
            case (p_kind)
                gdsii_rcb_pkg::RT_BGNSTR: p_cbox = gdsii_rcb_pkg::BOX_EMPTY;
                gdsii_rcb_pkg::RT_BOUNDARY: begin
                    p_elem = gdsii_rcb_pkg::EL_BOUNDARY;
                    p_pbox = gdsii_rcb_pkg::BOX_EMPTY;
                end
                gdsii_rcb_pkg::RT_PATH: p_elem = gdsii_rcb_pkg::EL_PATH;
                gdsii_rcb_pkg::RT_SREF: p_elem = gdsii_rcb_pkg::EL_SREF;
                gdsii_rcb_pkg::RT_AREF: p_elem = gdsii_rcb_pkg::EL_AREF;
                gdsii_rcb_pkg::RT_NODE: p_elem = gdsii_rcb_pkg::EL_NODE;
                gdsii_rcb_pkg::RT_BOX: p_elem = gdsii_rcb_pkg::EL_BOX;
                gdsii_rcb_pkg::RT_ENDEL: p_elem = gdsii_rcb_pkg::EL_NONE;
                default: ;
            endcase
        end
        post_result(st);
        if (st != gdsii_rcb_pkg::ST_OK || p_kind == gdsii_rcb_pkg::RT_ENDLIB) p_halted = 1'b1;
        p_pos = 0;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        int d;
        if (p_halted) return;
        case (p_pos)
            0: begin
                p_len = int'(b) << 8;
                p_head = 0;
                p_shift = 0;
                p_pos = 1;
            end
            1: begin
                p_len = p_len | int'(b);
                p_pos = 2;
            end
            2: begin
                p_kind = b;
                p_pos = 3;
            end
            3: begin
                p_dtype = b;
                if (p_len < 4 || p_len[0]) begin
                    post_result(gdsii_rcb_pkg::ST_LENGTH);
                    p_halted = 1'b1;
                    p_pos = 0;
                end else if (p_len == 4) begin
                    close_record();
                end else begin
                    p_pos = 4;
                end
            end
            default: begin
                d = p_pos - 4;
                if (d < 8) p_head = p_head | (64'(b) << (56 - 8 * d));
                p_shift = {p_shift[55:0], b};
                if (p_kind == gdsii_rcb_pkg::RT_XY && p_dtype == gdsii_rcb_pkg::DT_S32
                    && p_elem == gdsii_rcb_pkg::EL_BOUNDARY && d[2:0] == 3'd7) begin
                    p_pbox = grow(p_pbox, p_shift[63:32], p_shift[31:0]);
                    p_cbox = grow(p_cbox, p_shift[63:32], p_shift[31:0]);
                end
                if (p_pos + 1 >= p_len) close_record();
                else p_pos = p_pos + 1;
            end
        endcase
    endfunction

    // stream building
    task automatic put_word(input logic [31:0] w);
        body_q.push_back(w[31:24]);
        body_q.push_back(w[23:16]);
        body_q.push_back(w[15:8]);
        body_q.push_back(w[7:0]);
    endtask

    task automatic put_noise(input int n);
        repeat (n) body_q.push_back(8'($urandom));
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4, 5: return $urandom;
            default: return 32'($urandom_range(0, 2000)) - 32'd1000;
        endcase
    endfunction

    task automatic emit_rec(input logic [7:0] k, input logic [7:0] dt, input int len);
        stream_q.push_back(8'(len >> 8));
        stream_q.push_back(8'(len));
        stream_q.push_back(k);
        stream_q.push_back(dt);
        while (body_q.size() > 0) stream_q.push_back(body_q.pop_front());
    endtask

    task automatic emit_std(input logic [7:0] k);
        emit_rec(k, dtype_of(k), body_q.size() + 4);
    endtask

    task automatic emit_fill(input logic [7:0] k, input int n);
        put_noise(n);
        emit_std(k);
    endtask

    task automatic emit_xy(input int pairs, input int tail);
        repeat (pairs) begin
            put_word(pick_coord());
            put_word(pick_coord());
        end
        put_noise(tail);
        emit_std(gdsii_rcb_pkg::RT_XY);
    endtask

    task automatic emit_unknown();
        logic [7:0] k;
        k = 8'($urandom);
        while (dtype_of(k) != gdsii_rcb_pkg::DT_ANY) k = 8'($urandom);
        put_noise(2 * $urandom_range(0, 6));
        emit_rec(k, 8'($urandom), body_q.size() + 4);
    endtask

    task automatic emit_halting();
        case ($urandom_range(0, 5))
            0: emit_rec(8'($urandom), 8'($urandom), $urandom_range(0, 3));
            1: begin
                put_noise(4);
                emit_rec(gdsii_rcb_pkg::RT_LAYER, 8'($urandom), 11);
            end
            2: emit_rec(gdsii_rcb_pkg::RT_LAYER, gdsii_rcb_pkg::DT_S32, 6);
            3: begin
                emit_std(gdsii_rcb_pkg::RT_ENDEL);
                emit_fill(gdsii_rcb_pkg::RT_WIDTH, 4);
            end
            4: begin
                emit_std(gdsii_rcb_pkg::RT_SREF);
                emit_xy(2, 0);
            end
            default: emit_std(gdsii_rcb_pkg::RT_ENDLIB);
        endcase
        put_noise(6);
        while (body_q.size() > 0) stream_q.push_back(body_q.pop_front());
    endtask

    task automatic build_stream();
        // directed: boundary before any structure
        emit_std(gdsii_rcb_pkg::RT_BOUNDARY);
        body_q.push_back(8'h7F); body_q.push_back(8'hFF); body_q.push_back(8'hFF);
        body_q.push_back(8'hFF); put_word(32'h8000_0000);
        put_word(32'h8000_0000); put_word(32'h7FFF_FFFF);
        put_noise(6);
        emit_std(gdsii_rcb_pkg::RT_XY);
        emit_std(gdsii_rcb_pkg::RT_ENDEL);
        emit_fill(gdsii_rcb_pkg::RT_HEADER, 2);
        emit_fill(gdsii_rcb_pkg::RT_BGNLIB, 24);
        emit_fill(gdsii_rcb_pkg::RT_LIBNAME, 6);
        emit_fill(gdsii_rcb_pkg::RT_UNITS, 16);
        emit_fill(gdsii_rcb_pkg::RT_BGNSTR, 24);
        emit_fill(gdsii_rcb_pkg::RT_STRNAME, 4);
        emit_std(gdsii_rcb_pkg::RT_BOUNDARY);
        emit_fill(gdsii_rcb_pkg::RT_LAYER, 2);
        emit_fill(gdsii_rcb_pkg::RT_DATATYPE, 2);
        emit_xy(3, 0);
        emit_std(gdsii_rcb_pkg::RT_ENDEL);
        emit_std(gdsii_rcb_pkg::RT_PATH);
        emit_fill(gdsii_rcb_pkg::RT_WIDTH, 4);
        emit_fill(gdsii_rcb_pkg::RT_PATHTYPE, 2);
        emit_fill(gdsii_rcb_pkg::RT_BGNEXTN, 4);
        emit_fill(gdsii_rcb_pkg::RT_ENDEXTN, 4);
        emit_xy(2, 0);
        emit_std(gdsii_rcb_pkg::RT_ENDEL);
        emit_std(gdsii_rcb_pkg::RT_SREF);
        emit_fill(gdsii_rcb_pkg::RT_SNAME, 4);
        emit_fill(gdsii_rcb_pkg::RT_STRANS, 2);
        emit_fill(gdsii_rcb_pkg::RT_MAG, 8);
        emit_fill(gdsii_rcb_pkg::RT_ANGLE, 8);
        emit_xy(1, 0);
        emit_std(gdsii_rcb_pkg::RT_ENDEL);
        emit_std(gdsii_rcb_pkg::RT_AREF);
        emit_fill(gdsii_rcb_pkg::RT_COLROW, 4);
        emit_std(gdsii_rcb_pkg::RT_ENDEL);
        emit_std(gdsii_rcb_pkg::RT_NODE);
        emit_fill(gdsii_rcb_pkg::RT_NODETYPE, 2);
        emit_std(gdsii_rcb_pkg::RT_ENDEL);
        emit_std(gdsii_rcb_pkg::RT_BOX);
        emit_fill(gdsii_rcb_pkg::RT_BOXTYPE, 2);
        emit_std(gdsii_rcb_pkg::RT_ENDEL);
        emit_xy(0, 10);
        emit_unknown();
        emit_std(gdsii_rcb_pkg::RT_ENDSTR);
        pause_point = stream_q.size();

        while (stream_q.size() < 1900) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    emit_std(gdsii_rcb_pkg::RT_BOUNDARY);
                    if ($urandom_range(0, 1)) emit_fill(gdsii_rcb_pkg::RT_LAYER, 2);
                    emit_xy($urandom_range(1, 4),
                            ($urandom_range(0, 3) == 0) ? 2 * $urandom_range(1, 3) : 0);
                    emit_std(gdsii_rcb_pkg::RT_ENDEL);
                end
                4: begin
                    emit_std(gdsii_rcb_pkg::RT_PATH);
                    if ($urandom_range(0, 1)) emit_fill(gdsii_rcb_pkg::RT_WIDTH, 4);
                    if ($urandom_range(0, 1)) emit_fill(gdsii_rcb_pkg::RT_PATHTYPE, 2);
                    emit_xy($urandom_range(1, 3), 0);
                    emit_std(gdsii_rcb_pkg::RT_ENDEL);
                end
                5: begin
                    emit_std(gdsii_rcb_pkg::RT_SREF);
                    emit_fill(gdsii_rcb_pkg::RT_SNAME, 2 * $urandom_range(1, 4));
                    emit_xy(1, 0);
                    emit_std(gdsii_rcb_pkg::RT_ENDEL);
                end
                6: begin
                    emit_std(gdsii_rcb_pkg::RT_AREF);
                    emit_fill(gdsii_rcb_pkg::RT_COLROW, 4);
                    emit_xy(3, 0);
                    emit_std(gdsii_rcb_pkg::RT_ENDEL);
                end
                7: begin
                    if ($urandom_range(0, 1)) begin
                        emit_std(gdsii_rcb_pkg::RT_NODE);
                        emit_fill(gdsii_rcb_pkg::RT_NODETYPE, 2);
                    end else begin
                        emit_std(gdsii_rcb_pkg::RT_BOX);
                        emit_fill(gdsii_rcb_pkg::RT_BOXTYPE, 2);
                    end
                    emit_std(gdsii_rcb_pkg::RT_ENDEL);
                end
                8: begin
                    emit_std(gdsii_rcb_pkg::RT_ENDSTR);
                    emit_fill(gdsii_rcb_pkg::RT_BGNSTR, 24);
                    emit_fill(gdsii_rcb_pkg::RT_STRNAME, 2 * $urandom_range(1, 4));
                end
                default: emit_unknown();
            endcase
        end
        pause_point = pause_point + $urandom_range(0, 600);
        emit_halting();
    endtask

    // sender: bursts and gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_byte(s_stream_byte);
                sent++;
            end
            if (!s_valid || s_ready) begin
                if (burst_left > 0 && stream_q.size() > 0 &&
                    !(sent == pause_point && result_q.size() != 0)) begin
                    s_valid <= 1'b1;
                    s_stream_byte <= stream_q.pop_front();
                    burst_left--;
                end else begin
                    s_valid <= 1'b0;
                    if (gap_left > 0) begin
                        gap_left--;
                    end else if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end
                end
            end
        end
    end

    // receiver: stall pattern plus one long hold
    int ready_mode = 0;
    int hold_cnt = 0;
    always @(posedge aclk) begin
        cycle_no++;
        if (cycle_no % 97 == 0) ready_mode = $urandom_range(0, 3);
        if (cycle_no == 500) hold_cnt = 400;
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else begin
            case (ready_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 1) == 1);
                2: m_ready <= ($urandom_range(0, 5) == 0);
                default: m_ready <= ($urandom_range(0, 5) != 0);
            endcase
        end
    end

    // monitor
    always @(posedge aclk) begin
        rec_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (result_q.size() == 0) begin
                $error("unexpected transfer: rec_kind %h", m_rec_kind);
                errors++;
            end else begin
                e = result_q.pop_front();
                if (m_rec_kind !== e.kind) begin
                    $error("rec_kind exp %h got %h", e.kind, m_rec_kind); errors++;
                end
                if (m_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, m_status); errors++;
                end
                if (m_element !== e.element) begin
                    $error("element exp %0d got %0d", e.element, m_element); errors++;
                end
                if (m_value_raw !== e.raw) begin
                    $error("value_raw exp %h got %h", e.raw, m_value_raw); errors++;
                end
                if (m_poly_xmin !== e.pbox.xmin) begin
                    $error("poly_xmin exp %0d got %0d", e.pbox.xmin, m_poly_xmin); errors++;
                end
                if (m_poly_xmax !== e.pbox.xmax) begin
                    $error("poly_xmax exp %0d got %0d", e.pbox.xmax, m_poly_xmax); errors++;
                end
                if (m_poly_ymin !== e.pbox.ymin) begin
                    $error("poly_ymin exp %0d got %0d", e.pbox.ymin, m_poly_ymin); errors++;
                end
                if (m_poly_ymax !== e.pbox.ymax) begin
                    $error("poly_ymax exp %0d got %0d", e.pbox.ymax, m_poly_ymax); errors++;
                end
                if (m_cell_xmin !== e.cbox.xmin) begin
                    $error("cell_xmin exp %0d got %0d", e.cbox.xmin, m_cell_xmin); errors++;
                end
                if (m_cell_xmax !== e.cbox.xmax) begin
                    $error("cell_xmax exp %0d got %0d", e.cbox.xmax, m_cell_xmax); errors++;
                end
                if (m_cell_ymin !== e.cbox.ymin) begin
                    $error("cell_ymin exp %0d got %0d", e.cbox.ymin, m_cell_ymin); errors++;
                end
                if (m_cell_ymax !== e.cbox.ymax) begin
                    $error("cell_ymax exp %0d got %0d", e.cbox.ymax, m_cell_ymax); errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (cycle_no > LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        build_stream();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        while (stream_q.size() > 0 || s_valid) @(posedge aclk);
        while (result_q.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0 && result_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/gdsii_rcb_pkg.sv
hdl/gdsii_record_checker_bbox_unit.sv
test/gdsii_record_checker_bbox_unit_tb.sv
